// ===== rtl/paxf_pkg.sv =====
// shared types, constants and helpers for the polygon affine transform core
// depends on nothing; used by the core and its checker
`default_nettype none

package paxf_pkg;

    localparam int MAX_VERTICES = 8;
    localparam int IDX_W        = $clog2(MAX_VERTICES);
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);

    localparam int SLOT_W     = 3;
    localparam int OP_W       = 4;
    localparam int COORD_W    = 16;
    localparam int VCOUNT_W   = 4;
    localparam int STEP_W     = 10;
    localparam int COEF_W     = 15;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int PROD_W     = DIFF_W + COEF_W;
    localparam int ACC_W      = PROD_W + 1;
    localparam int WIDE_W     = COORD_W + 3;
    localparam int FRAC_SHIFT = 15;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;

    typedef logic [IDX_W-1:0]                t_idx;
    typedef logic [CNT_W-1:0]                t_cnt;
    typedef logic [SLOT_W-1:0]               t_slot;
    typedef logic [OP_W-1:0]                 t_op;
    typedef logic signed [COORD_W-1:0]       t_coord;
    typedef logic signed [DIFF_W-1:0]        t_diff;
    typedef logic signed [PROD_W-1:0]        t_prod;
    typedef logic signed [ACC_W-1:0]         t_acc;
    typedef logic signed [WIDE_W-1:0]        t_wide;
    typedef logic [VCOUNT_W-1:0]             t_vcount;
    typedef logic [STEP_W-1:0]               t_step;
    typedef logic [COEF_W-1:0]               t_coef;
    typedef logic [CFG_IDX_W-1:0]            t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0]           t_cfg_data;

    // operation codes; codes above redraw behave as redraw
    localparam t_op OP_LOAD   = 4'd0;
    localparam t_op OP_UP     = 4'd1;
    localparam t_op OP_DOWN   = 4'd2;
    localparam t_op OP_LEFT   = 4'd3;
    localparam t_op OP_RIGHT  = 4'd4;
    localparam t_op OP_GROW   = 4'd5;
    localparam t_op OP_SHRINK = 4'd6;
    localparam t_op OP_ROT_A  = 4'd7;
    localparam t_op OP_ROT_B  = 4'd8;
    localparam t_op OP_REDRAW = 4'd9;

    // configuration register indexes
    localparam t_cfg_idx CFG_VCOUNT = 3'd0;
    localparam t_cfg_idx CFG_STEP   = 3'd1;
    localparam t_cfg_idx CFG_COS    = 3'd2;
    localparam t_cfg_idx CFG_SIN    = 3'd3;

    localparam t_vcount RST_VCOUNT = 4'd5;
    localparam t_step   RST_STEP   = 10'd80;
    localparam t_coef   RST_COS    = 15'd32643;
    localparam t_coef   RST_SIN    = 15'd2854;

    typedef struct packed {
        t_op    op;
        t_slot  vertex_index;
        t_coord x_in;
        t_coord y_in;
    } t_in_word;

    typedef struct packed {
        t_slot  vertex_slot;
        t_coord x_out;
        t_coord y_out;
        logic   last;
    } t_out_word;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CENTER,
        ST_CALC,
        ST_READ,
        ST_DIFF,
        ST_MUL,
        ST_WB
    } t_state;

    // zero counts as one, counts past the table clamp to its depth
    function automatic t_cnt active_count(t_vcount vc);
        t_cnt res;
        if (vc == '0) begin
            res = t_cnt'(1);
        end else if (int'(vc) > MAX_VERTICES) begin
            res = t_cnt'(MAX_VERTICES);
        end else begin
            res = t_cnt'(vc);
        end
        return res;
    endfunction

    function automatic t_coord sat_coord(t_wide v);
        t_coord res;
        if (!v[WIDE_W-1] && (|v[WIDE_W-2:COORD_W-1])) begin
            res = {1'b0, {(COORD_W-1){1'b1}}};
        end else if (v[WIDE_W-1] && !(&v[WIDE_W-2:COORD_W-1])) begin
            res = {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            res = v[COORD_W-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/polygon_affine_transform_core.sv =====
// polygon affine transform core: vertex table, bounding-box walk, move/scale/rotate
// depends on paxf_pkg
`default_nettype none

// usage
// - input channel (i_in_valid / o_in_ready / i_in_word) takes one op word at a time
// - a load op writes one vertex slot and produces no output word
// - every other op walks the first n vertices twice: once through the table to
//   find the bounding box, then once more to update each vertex and emit it
// - output channel (o_out_valid / i_out_ready / o_out_word) gives n words in slot
//   order, the final one flagged with last
// - an op holds the core from acceptance until it can take the next word: a scan
//   of n table reads for the bounding box, the centre and calc states, then read,
//   difference, multiply and write-back per vertex, with write-back held by stalls;
//   the single-port vertex memory and the per-vertex multiply stage set this length
// - the first output word is registered by the first vertex's write-back
// - an output register holds a finished word; when the receiver stalls the
//   core waits in write-back, and the next op can be accepted while the last
//   word of the previous one is still waiting
// - configuration port (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data)
//   is always ready; registers: 0 vertex count, 1 move step, 2 cos, 3 sin
// - reset (synchronous, active low) empties the output register, restores the
//   register defaults and marks every vertex slot as zero through valid bits
module polygon_affine_transform_core (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output logic                  o_in_ready,
    input  paxf_pkg::t_in_word    i_in_word,
    output logic                  o_out_valid,
    input  wire                   i_out_ready,
    output paxf_pkg::t_out_word   o_out_word,
    input  wire                   i_cfg_valid,
    output logic                  o_cfg_ready,
    input  paxf_pkg::t_cfg_idx    i_cfg_index,
    input  paxf_pkg::t_cfg_data   i_cfg_data
);

    // configuration registers
    paxf_pkg::t_vcount r_vcount;
    paxf_pkg::t_step   r_step;
    paxf_pkg::t_coef   r_cos;
    paxf_pkg::t_coef   r_sin;

    // sequencer
    paxf_pkg::t_state r_state, n_state;
    paxf_pkg::t_op    r_op;
    paxf_pkg::t_cnt   r_n;
    paxf_pkg::t_cnt   r_idx;

    // vertex memory: x in the upper half, y in the lower half
    logic [2*paxf_pkg::COORD_W-1:0] mem [paxf_pkg::MAX_VERTICES];
    logic [2*paxf_pkg::COORD_W-1:0] r_rd_data;
    logic                           r_rd_ok;
    logic [paxf_pkg::MAX_VERTICES-1:0] r_vld;

    // bounding box walk
    logic             r_pend;
    logic             r_first;
    paxf_pkg::t_coord r_minx, r_maxx, r_miny, r_maxy;
    paxf_pkg::t_coord r_cx, r_cy;

    // per-vertex pipeline registers
    paxf_pkg::t_coord r_x, r_y;
    paxf_pkg::t_diff  r_dx, r_dy;
    paxf_pkg::t_prod  r_pxc, r_pxs, r_pyc, r_pys;

    // output register
    paxf_pkg::t_out_word r_out;
    logic                r_out_vld;

    // control decoded from state
    logic           in_fire;
    logic           load_wr;
    logic           scan_rd;
    logic           upd_rd;
    logic           wb_go;
    logic           scan_done;
    logic           vtx_last;
    paxf_pkg::t_idx rd_addr;
    paxf_pkg::t_idx wr_addr;
    logic           wr_en;
    logic [2*paxf_pkg::COORD_W-1:0] wr_data;

    paxf_pkg::t_coord rd_x, rd_y;
    paxf_pkg::t_diff  cx_sum, cy_sum;
    paxf_pkg::t_acc   acc_x, acc_y;
    paxf_pkg::t_wide  nx_w, ny_w;
    paxf_pkg::t_wide  x_w, y_w, cx_w, cy_w, dx_w, dy_w, step_w;
    paxf_pkg::t_coord nx_sat, ny_sat;

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out;

    assign in_fire   = i_in_valid && o_in_ready;
    assign scan_done = (paxf_pkg::t_cnt'(r_idx + 1'b1) == r_n);
    assign vtx_last  = scan_done;

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            paxf_pkg::ST_IDLE: begin
                if (in_fire && (i_in_word.op != paxf_pkg::OP_LOAD)) begin
                    n_state = paxf_pkg::ST_SCAN;
                end
            end
            paxf_pkg::ST_SCAN: begin
                if (scan_done) begin
                    n_state = paxf_pkg::ST_CENTER;
                end
            end
            paxf_pkg::ST_CENTER: n_state = paxf_pkg::ST_CALC;
            paxf_pkg::ST_CALC:   n_state = paxf_pkg::ST_READ;
            paxf_pkg::ST_READ:   n_state = paxf_pkg::ST_DIFF;
            paxf_pkg::ST_DIFF:   n_state = paxf_pkg::ST_MUL;
            paxf_pkg::ST_MUL:    n_state = paxf_pkg::ST_WB;
            paxf_pkg::ST_WB: begin
                if (wb_go) begin
                    n_state = vtx_last ? paxf_pkg::ST_IDLE : paxf_pkg::ST_READ;
                end
            end
            default: n_state = paxf_pkg::ST_IDLE;
        endcase
    end

    // ---------------- state outputs ----------------
    always_comb begin
        o_in_ready = 1'b0;
        scan_rd    = 1'b0;
        upd_rd     = 1'b0;
        wb_go      = 1'b0;
        case (r_state)
            paxf_pkg::ST_IDLE: o_in_ready = 1'b1;
            paxf_pkg::ST_SCAN: scan_rd    = 1'b1;
            paxf_pkg::ST_READ: upd_rd     = 1'b1;
            // write-back waits until the output register can take the word
            paxf_pkg::ST_WB:   wb_go      = !r_out_vld || i_out_ready;
            default: ;
        endcase
    end

    // load slots past the table depth are dropped
    assign load_wr = in_fire && (i_in_word.op == paxf_pkg::OP_LOAD)
                     && (int'(i_in_word.vertex_index) < paxf_pkg::MAX_VERTICES);

    assign rd_addr = r_idx[paxf_pkg::IDX_W-1:0];
    assign wr_en   = load_wr || wb_go;
    assign wr_addr = load_wr ? paxf_pkg::t_idx'(i_in_word.vertex_index)
                             : r_idx[paxf_pkg::IDX_W-1:0];
    assign wr_data = load_wr ? {i_in_word.x_in, i_in_word.y_in} : {nx_sat, ny_sat};

    // ---------------- vertex memory ----------------
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (scan_rd || upd_rd) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // slots never written read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            if (wr_en) begin
                r_vld[wr_addr] <= 1'b1;
            end
            if (scan_rd || upd_rd) begin
                r_rd_ok <= r_vld[rd_addr];
            end
        end
    end

    assign rd_x = r_rd_ok ? r_rd_data[2*paxf_pkg::COORD_W-1:paxf_pkg::COORD_W] : '0;
    assign rd_y = r_rd_ok ? r_rd_data[paxf_pkg::COORD_W-1:0] : '0;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= paxf_pkg::RST_VCOUNT;
            r_step   <= paxf_pkg::RST_STEP;
            r_cos    <= paxf_pkg::RST_COS;
            r_sin    <= paxf_pkg::RST_SIN;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                paxf_pkg::CFG_VCOUNT: r_vcount <= i_cfg_data[paxf_pkg::VCOUNT_W-1:0];
                paxf_pkg::CFG_STEP:   r_step   <= i_cfg_data[paxf_pkg::STEP_W-1:0];
                paxf_pkg::CFG_COS:    r_cos    <= i_cfg_data[paxf_pkg::COEF_W-1:0];
                paxf_pkg::CFG_SIN:    r_sin    <= i_cfg_data[paxf_pkg::COEF_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= paxf_pkg::ST_IDLE;
            r_idx     <= '0;
            r_pend    <= 1'b0;
            r_first   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= scan_rd;
            if (in_fire) begin
                r_idx   <= '0;
                r_first <= 1'b1;
            end else if (scan_rd || wb_go) begin
                r_idx <= paxf_pkg::t_cnt'(r_idx + 1'b1);
            end else if (r_state == paxf_pkg::ST_CALC) begin
                r_idx <= '0;
            end
            if (r_pend) begin
                r_first <= 1'b0;
            end
            if (wb_go) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // ---------------- datapath ----------------
    assign cx_sum = paxf_pkg::t_diff'(r_minx) + paxf_pkg::t_diff'(r_maxx);
    assign cy_sum = paxf_pkg::t_diff'(r_miny) + paxf_pkg::t_diff'(r_maxy);

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_op <= i_in_word.op;
            r_n  <= paxf_pkg::active_count(r_vcount);
        end
        // fold each returning table entry into the bounding box
        if (r_pend) begin
            if (r_first || (rd_x < r_minx)) r_minx <= rd_x;
            if (r_first || (rd_x > r_maxx)) r_maxx <= rd_x;
            if (r_first || (rd_y < r_miny)) r_miny <= rd_y;
            if (r_first || (rd_y > r_maxy)) r_maxy <= rd_y;
        end
        // centre is floor of the midpoint
        if (r_state == paxf_pkg::ST_CALC) begin
            r_cx <= paxf_pkg::t_coord'(cx_sum >>> 1);
            r_cy <= paxf_pkg::t_coord'(cy_sum >>> 1);
        end
        if (r_state == paxf_pkg::ST_DIFF) begin
            r_x  <= rd_x;
            r_y  <= rd_y;
            r_dx <= paxf_pkg::t_diff'(rd_x) - paxf_pkg::t_diff'(r_cx);
            r_dy <= paxf_pkg::t_diff'(rd_y) - paxf_pkg::t_diff'(r_cy);
        end
        // four 17x16 products, registered before the sums
        if (r_state == paxf_pkg::ST_MUL) begin
            r_pxc <= r_dx * $signed({1'b0, r_cos});
            r_pxs <= r_dx * $signed({1'b0, r_sin});
            r_pyc <= r_dy * $signed({1'b0, r_cos});
            r_pys <= r_dy * $signed({1'b0, r_sin});
        end
        if (wb_go) begin
            r_out.vertex_slot <= paxf_pkg::t_slot'(r_idx[paxf_pkg::IDX_W-1:0]);
            r_out.x_out       <= nx_sat;
            r_out.y_out       <= ny_sat;
            r_out.last        <= vtx_last;
        end
    end

    assign x_w    = paxf_pkg::t_wide'(r_x);
    assign y_w    = paxf_pkg::t_wide'(r_y);
    assign cx_w   = paxf_pkg::t_wide'(r_cx);
    assign cy_w   = paxf_pkg::t_wide'(r_cy);
    assign dx_w   = paxf_pkg::t_wide'(r_dx);
    assign dy_w   = paxf_pkg::t_wide'(r_dy);
    assign step_w = $signed({{(paxf_pkg::WIDE_W-paxf_pkg::STEP_W){1'b0}}, r_step});

    // new coordinates, all formed from the old ones
    always_comb begin
        acc_x = '0;
        acc_y = '0;
        nx_w  = x_w;
        ny_w  = y_w;
        case (r_op)
            paxf_pkg::OP_UP:     ny_w = y_w - step_w;
            paxf_pkg::OP_DOWN:   ny_w = y_w + step_w;
            paxf_pkg::OP_LEFT:   nx_w = x_w - step_w;
            paxf_pkg::OP_RIGHT:  nx_w = x_w + step_w;
            paxf_pkg::OP_GROW: begin
                nx_w = cx_w + (dx_w <<< 1);
                ny_w = cy_w + (dy_w <<< 1);
            end
            paxf_pkg::OP_SHRINK: begin
                nx_w = cx_w + (dx_w >>> 1);
                ny_w = cy_w + (dy_w >>> 1);
            end
            paxf_pkg::OP_ROT_A: begin
                acc_x = paxf_pkg::t_acc'(r_pxc) + paxf_pkg::t_acc'(r_pys);
                acc_y = paxf_pkg::t_acc'(r_pyc) - paxf_pkg::t_acc'(r_pxs);
                nx_w  = cx_w + paxf_pkg::t_wide'(acc_x >>> paxf_pkg::FRAC_SHIFT);
                ny_w  = cy_w + paxf_pkg::t_wide'(acc_y >>> paxf_pkg::FRAC_SHIFT);
            end
            paxf_pkg::OP_ROT_B: begin
                acc_x = paxf_pkg::t_acc'(r_pxc) - paxf_pkg::t_acc'(r_pys);
                acc_y = paxf_pkg::t_acc'(r_pxs) + paxf_pkg::t_acc'(r_pyc);
                nx_w  = cx_w + paxf_pkg::t_wide'(acc_x >>> paxf_pkg::FRAC_SHIFT);
                ny_w  = cy_w + paxf_pkg::t_wide'(acc_y >>> paxf_pkg::FRAC_SHIFT);
            end
            default: ; // redraw and unused codes leave the vertex as it is
        endcase
    end

    assign nx_sat = paxf_pkg::sat_coord(nx_w);
    assign ny_sat = paxf_pkg::sat_coord(ny_w);

endmodule

`default_nettype wire

// ===== rtl/paxf_checker.sv =====
// port-level checks for the polygon affine transform core, bound to the top level
// depends on paxf_pkg
`default_nettype none

module paxf_checker (
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 i_in_valid,
    input wire                 o_in_ready,
    input paxf_pkg::t_in_word  i_in_word,
    input wire                 o_out_valid,
    input wire                 i_out_ready,
    input paxf_pkg::t_out_word o_out_word
);

    logic in_fire;
    logic out_fire;

    assign in_fire  = i_in_valid && o_in_ready;
    assign out_fire = o_out_valid && i_out_ready;

    // a waiting output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("output word changed while stalled");

    // reset empties the output register
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // no new op while words of the current polygon are still to come
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_word.last |-> !o_in_ready)
        else $error("input ready in the middle of a polygon");

    // a non-load op keeps the core busy
    a_op_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && (i_in_word.op != paxf_pkg::OP_LOAD) |=> !o_in_ready)
        else $error("input ready right after an op");

    // after the last word only the first word of a new polygon may follow
    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_fire && o_out_word.last |=>
            !o_out_valid || (o_out_word.vertex_slot == paxf_pkg::t_slot'(0)))
        else $error("output word right after the last one is not slot zero");

endmodule

bind polygon_affine_transform_core paxf_checker u_paxf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_word   (i_in_word),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_word  (o_out_word)
);

`default_nettype wire

// ===== bench/polygon_affine_transform_core_test.sv =====
// self-checking bench for polygon_affine_transform_core: random and directed op words,
// an in-bench shadow of the vertex table predicts every emitted vertex word
// depends on paxf_pkg and the core
`timescale 1ns / 100ps
module polygon_affine_transform_core_test;

    localparam int MAX_GAP       = 19;
    localparam int SETTLE_CYCLES = 60;
    localparam int PHASES        = 10;
    localparam int PHASE_WORDS   = 30;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    paxf_pkg::t_in_word  in_word   = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    paxf_pkg::t_out_word out_word;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    paxf_pkg::t_cfg_idx  cfg_index = '0;
    paxf_pkg::t_cfg_data cfg_data  = '0;

    // shadow of the core's table and registers
    paxf_pkg::t_coord    shape_x [paxf_pkg::MAX_VERTICES];
    paxf_pkg::t_coord    shape_y [paxf_pkg::MAX_VERTICES];
    paxf_pkg::t_vcount   count_cfg = paxf_pkg::RST_VCOUNT;
    paxf_pkg::t_step     step_cfg  = paxf_pkg::RST_STEP;
    paxf_pkg::t_coef     cos_cfg   = paxf_pkg::RST_COS;
    paxf_pkg::t_coef     sin_cfg   = paxf_pkg::RST_SIN;

    paxf_pkg::t_in_word  pending_words[$];
    paxf_pkg::t_out_word expected_vertices[$];

    int          words_sent       = 0;
    int          words_taken      = 0;
    int          vertices_taken   = 0;
    int          vertices_seen_rx = 0;
    int          tx_wait          = 0;
    int          rx_wait          = 0;
    int          fault_count      = 0;
    bit          no_gaps          = 1'b0;

    polygon_affine_transform_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial begin
        for (int i = 0; i < paxf_pkg::MAX_VERTICES; i++) begin
            shape_x[i] = '0;
            shape_y[i] = '0;
        end
    end

    // ------------------------------------------------------------------
    // shadow model
    // ------------------------------------------------------------------

    // vertices in use: zero acts as one, large counts clamp to the table
    function automatic int span_of_polygon();
        int n;
        n = int'(count_cfg);
        if (n == 0) begin
            n = 1;
        end else if (n > paxf_pkg::MAX_VERTICES) begin
            n = paxf_pkg::MAX_VERTICES;
        end
        return n;
    endfunction

    function automatic paxf_pkg::t_coord clip_coord(longint v);
        paxf_pkg::t_coord r;
        if (v > 32767) begin
            r = 16'sh7fff;
        end else if (v < -32768) begin
            r = 16'sh8000;
        end else begin
            r = paxf_pkg::t_coord'(v);
        end
        return r;
    endfunction

    // apply one accepted op word to the shadow table and queue the vertices it emits
    task automatic transform_polygon(paxf_pkg::t_in_word w);
        longint              lo_x, hi_x, lo_y, hi_y, cx, cy;
        longint              x, y, dx, dy, nx, ny, stp, c, s;
        int                  n;
        paxf_pkg::t_out_word v;
        if (w.op == paxf_pkg::OP_LOAD) begin
            shape_x[w.vertex_index] = w.x_in;
            shape_y[w.vertex_index] = w.y_in;
        end else begin
            n    = span_of_polygon();
            lo_x = shape_x[0];
            hi_x = shape_x[0];
            lo_y = shape_y[0];
            hi_y = shape_y[0];
            for (int i = 1; i < n; i++) begin
                if (shape_x[i] > hi_x) hi_x = shape_x[i];
                if (shape_x[i] < lo_x) lo_x = shape_x[i];
                if (shape_y[i] > hi_y) hi_y = shape_y[i];
                if (shape_y[i] < lo_y) lo_y = shape_y[i];
            end
            // bounding-box centre, floor of the midpoint
            cx  = (lo_x + hi_x) >>> 1;
            cy  = (lo_y + hi_y) >>> 1;
            stp = longint'(step_cfg);
            c   = longint'(cos_cfg);
            s   = longint'(sin_cfg);
            for (int i = 0; i < n; i++) begin
                x  = shape_x[i];
                y  = shape_y[i];
                dx = x - cx;
                dy = y - cy;
                nx = x;
                ny = y;
                case (w.op)
                    paxf_pkg::OP_UP:     ny = y - stp;
                    paxf_pkg::OP_DOWN:   ny = y + stp;
                    paxf_pkg::OP_LEFT:   nx = x - stp;
                    paxf_pkg::OP_RIGHT:  nx = x + stp;
                    paxf_pkg::OP_GROW: begin
                        nx = cx + 2 * dx;
                        ny = cy + 2 * dy;
                    end
                    paxf_pkg::OP_SHRINK: begin
                        nx = cx + (dx >>> 1);
                        ny = cy + (dy >>> 1);
                    end
                    paxf_pkg::OP_ROT_A: begin
                        nx = cx + ((dx * c + dy * s) >>> paxf_pkg::FRAC_SHIFT);
                        ny = cy + ((dy * c - dx * s) >>> paxf_pkg::FRAC_SHIFT);
                    end
                    paxf_pkg::OP_ROT_B: begin
                        nx = cx + ((dx * c - dy * s) >>> paxf_pkg::FRAC_SHIFT);
                        ny = cy + ((dx * s + dy * c) >>> paxf_pkg::FRAC_SHIFT);
                    end
                    default: ;   // redraw and unused codes leave the table alone
                endcase
                shape_x[i] = clip_coord(nx);
                shape_y[i] = clip_coord(ny);
            end
            for (int i = 0; i < n; i++) begin
                v.vertex_slot = paxf_pkg::t_slot'(i);
                v.x_out       = shape_x[i];
                v.y_out       = shape_y[i];
                v.last        = (i == n - 1);
                expected_vertices.push_back(v);
            end
        end
    endtask

    task automatic apply_register(paxf_pkg::t_cfg_idx idx, paxf_pkg::t_cfg_data val);
        case (idx)
            paxf_pkg::CFG_VCOUNT: count_cfg = paxf_pkg::t_vcount'(val);
            paxf_pkg::CFG_STEP:   step_cfg  = paxf_pkg::t_step'(val);
            paxf_pkg::CFG_COS:    cos_cfg   = paxf_pkg::t_coef'(val);
            paxf_pkg::CFG_SIN:    sin_cfg   = paxf_pkg::t_coef'(val);
            default: ;  // unused indexes are dropped
        endcase
    endtask

    // ------------------------------------------------------------------
    // driver, receiver and monitor
    // ------------------------------------------------------------------

    function automatic int draw_gap();
        return no_gaps ? 0 : int'($urandom_range(0, MAX_GAP));
    endfunction

    // op word driver: holds a word until taken, then waits its drawn gap
    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || words_taken == words_sent) begin
            if (tx_wait > 0) begin
                in_valid <= 1'b0;
                tx_wait--;
            end else if (pending_words.size() != 0) begin
                in_word  <= pending_words.pop_front();
                in_valid <= 1'b1;
                words_sent++;
                tx_wait = draw_gap();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // vertex word receiver: stalls a drawn number of cycles after each word
    always @(negedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (vertices_taken != vertices_seen_rx) begin
                vertices_seen_rx = vertices_taken;
                rx_wait          = draw_gap();
            end
            if (rx_wait > 0) begin
                out_ready <= 1'b0;
                rx_wait--;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // handshake monitor: check emitted vertices, then feed the shadow model
    always @(posedge clk) begin : monitor
        paxf_pkg::t_out_word want;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                vertices_taken++;
                if (expected_vertices.size() == 0) begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display("unexpected vertex word: slot %0d x %0d y %0d last %0b",
                                 out_word.vertex_slot, out_word.x_out, out_word.y_out,
                                 out_word.last);
                end else begin
                    want = expected_vertices.pop_front();
                    if (out_word.vertex_slot !== want.vertex_slot ||
                        out_word.x_out !== want.x_out || out_word.y_out !== want.y_out ||
                        out_word.last !== want.last) begin
                        fault_count++;
                        if (fault_count <= 10)
                            $display({"vertex mismatch: slot %0d/%0d x %0d/%0d y %0d/%0d",
                                      " last %0b/%0b (expected/actual)"},
                                     want.vertex_slot, out_word.vertex_slot,
                                     want.x_out, out_word.x_out, want.y_out, out_word.y_out,
                                     want.last, out_word.last);
                    end
                end
            end
            if (in_valid && in_ready) begin
                words_taken++;
                transform_polygon(in_word);
            end
            if (cfg_valid && cfg_ready)
                apply_register(cfg_index, cfg_data);
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    function automatic void queue_word(paxf_pkg::t_op op, int slot, paxf_pkg::t_coord x,
                                       paxf_pkg::t_coord y);
        paxf_pkg::t_in_word w;
        w.op           = op;
        w.vertex_index = paxf_pkg::t_slot'(slot);
        w.x_in         = x;
        w.y_in         = y;
        pending_words.push_back(w);
    endfunction

    // mostly modest coordinates so rotations stay inside range, some full range
    function automatic paxf_pkg::t_coord rand_coord();
        paxf_pkg::t_coord v;
        int unsigned      pick;
        pick = $urandom_range(0, 19);
        if (pick < 12) begin
            v = paxf_pkg::t_coord'(int'($urandom_range(0, 8000)) - 4000);
        end else if (pick < 17) begin
            v = paxf_pkg::t_coord'($urandom);
        end else begin
            case ($urandom_range(0, 3))
                0:       v = 16'sh7fff;
                1:       v = 16'sh8000;
                2:       v = 16'sh0000;
                default: v = 16'shffff;
            endcase
        end
        return v;
    endfunction

    function automatic paxf_pkg::t_op rand_op();
        paxf_pkg::t_op op;
        if ($urandom_range(0, 11) == 0)
            op = paxf_pkg::t_op'($urandom_range(int'(paxf_pkg::OP_REDRAW) + 1, 15));
        else
            op = paxf_pkg::t_op'($urandom_range(int'(paxf_pkg::OP_UP),
                                                int'(paxf_pkg::OP_REDRAW)));
        return op;
    endfunction

    task automatic write_register(paxf_pkg::t_cfg_idx idx, paxf_pkg::t_cfg_data val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // block until the core has drained, then let any trailing work finish
    task automatic idle_wait();
        while (!(pending_words.size() == 0 && !in_valid && words_taken == words_sent &&
                 expected_vertices.size() == 0))
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // register set for one phase, the first ones pinned to the extremes
    task automatic program_phase(int ph);
        paxf_pkg::t_cfg_data vc, st, cs, sn;
        vc = paxf_pkg::t_cfg_data'($urandom_range(0, 15));
        st = paxf_pkg::t_cfg_data'($urandom);
        cs = paxf_pkg::t_cfg_data'($urandom);
        sn = paxf_pkg::t_cfg_data'($urandom);
        case (ph)
            0: begin vc = 15'd8;  st = 15'd1023; cs = 15'd32767; sn = 15'd0;     end
            1: begin vc = 15'd1;  st = 15'd0;    cs = 15'd0;     sn = 15'd32767; end
            2: begin vc = 15'd0;  st = 15'h7fff; cs = 15'd32767; sn = 15'd32767; end
            3: begin vc = 15'd15;                cs = 15'd0;     sn = 15'd0;     end
            4: vc = 15'd9;
            default: begin
                if (ph % 2 == 1) begin
                    cs = paxf_pkg::RST_COS;
                    sn = paxf_pkg::RST_SIN;
                end
            end
        endcase
        write_register(paxf_pkg::CFG_VCOUNT, vc);
        write_register(paxf_pkg::CFG_STEP, st);
        write_register(paxf_pkg::CFG_COS, cs);
        write_register(paxf_pkg::CFG_SIN, sn);
        write_register(paxf_pkg::t_cfg_idx'(paxf_pkg::CFG_SIN + $urandom_range(1, 4)),
                       paxf_pkg::t_cfg_data'($urandom));
    endtask

    // mostly whole polygons followed by a run of ops, the rest stray words
    task automatic fill_phase(int target);
        int made, n, k;
        made = 0;
        n    = span_of_polygon();
        while (made < target) begin
            if ($urandom_range(0, 9) < 7) begin
                for (int j = 0; j < n; j++)
                    queue_word(paxf_pkg::OP_LOAD, j, rand_coord(), rand_coord());
                k = $urandom_range(2, 6);
                repeat (k)
                    queue_word(rand_op(), $urandom_range(0, 7),
                               paxf_pkg::t_coord'($urandom),
                               paxf_pkg::t_coord'($urandom));
                made += n + k;
            end else begin
                queue_word(paxf_pkg::t_op'($urandom_range(0, 15)), $urandom_range(0, 7),
                           rand_coord(), rand_coord());
                made++;
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: extreme vertices under reset registers, every op code
        queue_word(paxf_pkg::OP_LOAD, 0, 16'sh7fff, 16'sh8000);
        queue_word(paxf_pkg::OP_LOAD, 1, 16'sh8000, 16'sh7fff);
        queue_word(paxf_pkg::OP_LOAD, 2, 16'sh0000, 16'sh0000);
        queue_word(paxf_pkg::OP_LOAD, 3, 16'shffff, 16'sh0001);
        queue_word(paxf_pkg::OP_LOAD, 4, 16'sh0064, -16'sh0064);
        queue_word(paxf_pkg::OP_LOAD, 7, -16'sh0005, 16'sh0005); // stored, outside the polygon
        queue_word(paxf_pkg::OP_UP, 0, '0, '0);
        queue_word(paxf_pkg::OP_DOWN, 0, '0, '0);
        queue_word(paxf_pkg::OP_LEFT, 0, '0, '0);
        queue_word(paxf_pkg::OP_RIGHT, 0, '0, '0);
        queue_word(paxf_pkg::OP_GROW, 0, '0, '0);
        queue_word(paxf_pkg::OP_SHRINK, 0, '0, '0);
        queue_word(paxf_pkg::OP_ROT_A, 0, '0, '0);
        queue_word(paxf_pkg::OP_ROT_B, 0, '0, '0);
        queue_word(paxf_pkg::OP_REDRAW, 0, '0, '0);
        queue_word(paxf_pkg::t_op'(int'(paxf_pkg::OP_REDRAW) + 1), 7, 16'sh7fff, 16'sh7fff);
        queue_word(paxf_pkg::t_op'(15), 7, 16'sh8000, 16'sh8000);
        queue_word(paxf_pkg::OP_LOAD, 0, 16'sh7fff, 16'sh7fff);
        queue_word(paxf_pkg::OP_GROW, 0, '0, '0);                // saturates both ways
        queue_word(paxf_pkg::OP_SHRINK, 0, '0, '0);
        idle_wait();

        // random phases; the sender waits for a full drain between them
        for (int ph = 0; ph < PHASES; ph++) begin
            no_gaps = (ph == 2 || ph == 6);
            program_phase(ph);
            fill_phase(PHASE_WORDS);
            idle_wait();
        end

        if (fault_count == 0 && expected_vertices.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
